/* rtl/bcpe_pkg.sv */
// bcpe_pkg: types, constants and small helpers for the Bezier point evaluator.
// Depends on nothing; used by rtl/bezier_curve_point_eval.sv.
`default_nettype none

package bcpe_pkg;

  localparam int unsigned POINT_REGS = 4;   // control point registers
  localparam int unsigned LIMBS      = 4;   // 16-bit limbs of the exact sum
  localparam int unsigned LIMB_W     = 16;
  localparam int unsigned SUM_W      = LIMBS * LIMB_W;
  localparam int unsigned PARAM_W    = 17;  // Q0.16 plus the bit for exactly one
  localparam int unsigned CARRY_W    = 18;
  localparam int unsigned PROD_W     = LIMB_W + CARRY_W;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned CFG_W      = 32;

  localparam logic [PARAM_W-1:0] T_ONE = 17'h10000;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_COUNT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_POINT0 = 3'd1;
  localparam logic [IDX_W-1:0] REG_POINT1 = 3'd2;
  localparam logic [IDX_W-1:0] REG_POINT2 = 3'd3;
  localparam logic [IDX_W-1:0] REG_POINT3 = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  typedef logic [LIMBS-1:0][LIMB_W-1:0] limbs_t;

  // binomial coefficient C(n,i) for degree up to three
  function automatic logic [1:0] binom(input logic [1:0] n, input logic [1:0] i);
    logic [1:0] c;
    c = 2'd1;
    if ((n == 2'd2 && i == 2'd1)) c = 2'd2;
    if ((n == 2'd3) && (i == 2'd1 || i == 2'd2)) c = 2'd3;
    return c;
  endfunction

  // rounding bias: half of one output step, 2^(16n-1)
  function automatic logic [SUM_W-1:0] half_step(input logic [1:0] n);
    logic [SUM_W-1:0] h;
    case (n)
      2'd2:    h = SUM_W'(64'h0000_0000_8000_0000);
      2'd3:    h = SUM_W'(64'h0000_8000_0000_0000);
      default: h = SUM_W'(64'h0000_0000_0000_8000);
    endcase
    return h;
  endfunction

  // scale the biased sum back to Q8.8, saturate, undo the offset
  function automatic logic [15:0] finish(input logic [SUM_W-1:0] s, input logic [1:0] n);
    logic [47:0] r;
    logic [15:0] v;
    case (n)
      2'd2:    r = {16'd0, s[63:32]};
      2'd3:    r = {32'd0, s[63:48]};
      default: r = s[63:16];
    endcase
    v = (|r[47:16]) ? 16'hFFFF : r[15:0];
    return v ^ 16'h8000;
  endfunction

endpackage

`default_nettype wire

/* rtl/bezier_curve_point_eval.sv */
// bezier_curve_point_eval: Bernstein-form Bezier point evaluator, one shared
// 16x17 limb multiplier under a small sequencer. Depends on rtl/bcpe_pkg.sv.
//
//  channel   direction  contents
//  s_axis    in         tdata[16:0] curve_param (Q0.16), rest zero
//  m_axis    out        tdata[15:0] x_pos, tdata[31:16] y_pos (Q8.8)
//  cfg       in         cfg_we_i / cfg_idx_i / cfg_data_i, write only
//
// Each term of each coordinate is built limb by limb: offset point times
// n factors of (1-t) or t, then the binomial, each factor one pass over the
// four limbs, then one add into the exact sum, n the degree.
// Ready is high only in idle; the result sits in an output register, so the
// next item is taken while it waits. Reset gives the default cubic curve.
`default_nettype none

module bezier_curve_point_eval #(
  parameter int unsigned MAX_POINTS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [16:0] curve_param
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [15:0] x_pos, [31:16] y_pos
);

  localparam int unsigned CapPoints =
      (MAX_POINTS < bcpe_pkg::POINT_REGS) ? MAX_POINTS : bcpe_pkg::POINT_REGS;

  bcpe_pkg::state_e state_q, state_d;

  logic [2:0]  point_count_q;
  logic [31:0] points_q [bcpe_pkg::POINT_REGS];

  logic [1:0]  n_q, pt_q, fac_q, limb_q;
  logic        coord_q;
  logic [bcpe_pkg::PARAM_W-1:0] t_q, u_q;
  bcpe_pkg::limbs_t             v_q;
  logic [bcpe_pkg::CARRY_W-1:0] carry_q;
  logic [bcpe_pkg::SUM_W-1:0]   acc_x_q, acc_y_q;
  logic        m_valid_q;
  logic [31:0] m_data_q;

  logic [2:0]  cnt_used;
  logic [1:0]  n_new;
  logic [bcpe_pkg::PARAM_W-1:0] t_in, factor;
  logic [15:0] coord_val;
  logic [bcpe_pkg::PROD_W-1:0]  mul_prod;
  logic        out_free, last_limb, last_fac;

  assign s_axis_tready = (state_q == bcpe_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    cnt_used = point_count_q;
    if (cnt_used < 3'd2) cnt_used = 3'd2;
    if (cnt_used > 3'(CapPoints)) cnt_used = 3'(CapPoints);
  end
  assign n_new = 2'(cnt_used - 3'd1);

  // parameter above one is held at one
  assign t_in = (s_axis_tdata[16] && |s_axis_tdata[15:0]) ? bcpe_pkg::T_ONE
                                                           : s_axis_tdata[16:0];

  assign coord_val = coord_q ? (points_q[pt_q][15:0] ^ 16'h8000)
                             : (points_q[pt_q][31:16] ^ 16'h8000);

  // factor order per term: (1-t) x (n-i), t x i, then the binomial
  always_comb begin
    if (fac_q == n_q) begin
      factor = bcpe_pkg::PARAM_W'(bcpe_pkg::binom(n_q, pt_q));
    end else if (fac_q < 2'(n_q - pt_q)) begin
      factor = u_q;
    end else begin
      factor = t_q;
    end
  end

  assign mul_prod = bcpe_pkg::PROD_W'(v_q[limb_q]) * bcpe_pkg::PROD_W'(factor)
                  + bcpe_pkg::PROD_W'(carry_q);
  assign last_limb = (limb_q == 2'(bcpe_pkg::LIMBS - 1));
  assign last_fac  = (fac_q == n_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bcpe_pkg::ST_IDLE: if (s_axis_tvalid) state_d = bcpe_pkg::ST_LOAD;
      bcpe_pkg::ST_LOAD: state_d = bcpe_pkg::ST_MUL;
      bcpe_pkg::ST_MUL:  if (last_limb && last_fac) state_d = bcpe_pkg::ST_ACC;
      bcpe_pkg::ST_ACC: begin
        if (coord_q && pt_q == n_q) state_d = bcpe_pkg::ST_FIN;
        else                        state_d = bcpe_pkg::ST_LOAD;
      end
      bcpe_pkg::ST_FIN:  if (out_free) state_d = bcpe_pkg::ST_IDLE;
      default:           state_d = bcpe_pkg::ST_IDLE;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= bcpe_pkg::ST_IDLE;
      point_count_q <= 3'd4;
      points_q[0]   <= 32'h0000_0000;
      points_q[1]   <= 32'h0000_0100;
      points_q[2]   <= 32'h0100_FF00;
      points_q[3]   <= 32'h0100_0000;
      pt_q          <= '0;
      fac_q         <= '0;
      limb_q        <= '0;
      coord_q       <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          bcpe_pkg::REG_COUNT:  point_count_q <= cfg_data_i[2:0];
          bcpe_pkg::REG_POINT0: points_q[0]   <= cfg_data_i;
          bcpe_pkg::REG_POINT1: points_q[1]   <= cfg_data_i;
          bcpe_pkg::REG_POINT2: points_q[2]   <= cfg_data_i;
          bcpe_pkg::REG_POINT3: points_q[3]   <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        bcpe_pkg::ST_IDLE: begin
          pt_q    <= '0;
          coord_q <= 1'b0;
        end
        bcpe_pkg::ST_LOAD: begin
          fac_q  <= '0;
          limb_q <= '0;
        end
        bcpe_pkg::ST_MUL: begin
          limb_q <= limb_q + 2'd1;
          if (last_limb && !last_fac) fac_q <= fac_q + 2'd1;
        end
        bcpe_pkg::ST_ACC: begin
          coord_q <= !coord_q;
          if (coord_q) pt_q <= pt_q + 2'd1;
        end
        default: ;
      endcase

      if (state_q == bcpe_pkg::ST_FIN && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      bcpe_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          t_q     <= t_in;
          u_q     <= bcpe_pkg::T_ONE - t_in;
          n_q     <= n_new;
          acc_x_q <= bcpe_pkg::half_step(n_new);
          acc_y_q <= bcpe_pkg::half_step(n_new);
        end
      end
      bcpe_pkg::ST_LOAD: begin
        v_q     <= bcpe_pkg::limbs_t'(bcpe_pkg::SUM_W'(coord_val));
        carry_q <= '0;
      end
      bcpe_pkg::ST_MUL: begin
        v_q[limb_q] <= mul_prod[bcpe_pkg::LIMB_W-1:0];
        carry_q     <= last_limb ? '0 : mul_prod[bcpe_pkg::PROD_W-1:bcpe_pkg::LIMB_W];
      end
      bcpe_pkg::ST_ACC: begin
        if (coord_q) acc_y_q <= acc_y_q + bcpe_pkg::SUM_W'(v_q);
        else         acc_x_q <= acc_x_q + bcpe_pkg::SUM_W'(v_q);
      end
      bcpe_pkg::ST_FIN: begin
        if (out_free) begin
          m_data_q <= {bcpe_pkg::finish(acc_y_q, n_q), bcpe_pkg::finish(acc_x_q, n_q)};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* bench/bezier_curve_point_eval_tb.sv */
`timescale 1ns / 1ps
// bezier_curve_point_eval_tb: self-checking bench for the Bezier point evaluator.
// Predicts every point from its own copy of the registers and compares it with
// the block's output. Depends on rtl/bcpe_pkg.sv and rtl/bezier_curve_point_eval.sv.

module bezier_curve_point_eval_tb;

  localparam int unsigned MAX_PTS       = 4;
  localparam int unsigned PT_CAP        =
      (MAX_PTS < bcpe_pkg::POINT_REGS) ? MAX_PTS : bcpe_pkg::POINT_REGS;
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned BATCH_ITEMS   = 125;
  localparam logic [16:0] PARAM_MAX     = 17'h1FFFF;
  localparam logic [2:0]  IDX_TOP       = 3'd7;

  typedef struct packed {
    logic [15:0] y_pos;
    logic [15:0] x_pos;
  } point_t;

  class point_scoreboard;
    logic [2:0]  count_reg;
    logic [31:0] ctrl_pts [bcpe_pkg::POINT_REGS];
    point_t      expected_q [$];
    int unsigned errors;

    function new();
      count_reg   = 3'd4;
      ctrl_pts[0] = 32'h0000_0000;
      ctrl_pts[1] = 32'h0000_0100;
      ctrl_pts[2] = 32'h0100_FF00;
      ctrl_pts[3] = 32'h0100_0000;
      errors      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      if (idx == bcpe_pkg::REG_COUNT) begin
        count_reg = value[2:0];
      end else if (idx <= bcpe_pkg::REG_POINT3) begin
        ctrl_pts[2'(idx - bcpe_pkg::REG_POINT0)] = value;
      end
    endfunction

    // drop 16n fraction bits with round half up, saturate, remove the offset
    function logic [15:0] to_q8_8(bit [63:0] s, int unsigned shift);
      bit [64:0] r;
      r = ({1'b0, s} + (65'd1 << (shift - 1))) >> shift;
      if (r > 65'd65535) r = 65'd65535;
      return r[15:0] ^ 16'h8000;
    endfunction

    function point_t eval_curve(logic [16:0] param);
      bit [63:0]   t, u, w, binom_c, sx, sy;
      int unsigned used, n;
      point_t      p;
      used = count_reg;
      if (used < 2) used = 2;
      if (used > PT_CAP) used = PT_CAP;
      n = used - 1;
      t = (param > bcpe_pkg::T_ONE) ? 64'(bcpe_pkg::T_ONE) : 64'(param);
      u = 64'(bcpe_pkg::T_ONE) - t;
      binom_c = 64'd1;
      sx = '0;
      sy = '0;
      for (int unsigned i = 0; i <= n; i++) begin
        w = binom_c;
        repeat (n - i) w = w * u;
        repeat (i) w = w * t;
        // offset binary keeps every term unsigned
        sx += w * 64'(ctrl_pts[i][31:16] ^ 16'h8000);
        sy += w * 64'(ctrl_pts[i][15:0] ^ 16'h8000);
        binom_c = binom_c * (n - i) / (i + 1);
      end
      p.x_pos = to_q8_8(sx, 16 * n);
      p.y_pos = to_q8_8(sy, 16 * n);
      return p;
    endfunction

    function void note_param(logic [16:0] param);
      expected_q.push_back(eval_curve(param));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_point(logic [31:0] data);
      point_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("point %h with nothing outstanding", data));
        return;
      end
      want = expected_q.pop_front();
      if (data[15:0] !== want.x_pos)
        report_mismatch($sformatf("x_pos %h, want %h", data[15:0], want.x_pos));
      if (data[31:16] !== want.y_pos)
        report_mismatch($sformatf("y_pos %h, want %h", data[31:16], want.y_pos));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  int unsigned     tx_idle_pct  = 24;
  int unsigned     rx_stall_pct = 67;
  int unsigned     quiet_cycles = 0;
  point_scoreboard sb;

  logic [16:0] corner_params [7] = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536,
                                     17'd65537, PARAM_MAX};
  logic [2:0]  phase_counts [9]  = '{3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd5, 3'd7, 3'd6, 3'd4};

  bezier_curve_point_eval #(
    .MAX_POINTS(MAX_PTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_point(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_param(logic [16:0] param);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, param};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_param(param);
  endtask

  // hold the sender off until every outstanding point is back
  task automatic drain_points();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic load_curve(logic [2:0] count, logic [31:0] p0, logic [31:0] p1,
                            logic [31:0] p2, logic [31:0] p3);
    drain_points();
    // upper bits of the count write are don't-care; spare indexes are ignored
    cfg_write(bcpe_pkg::REG_COUNT, {29'($urandom()), count});
    cfg_write(3'($urandom_range(int'(IDX_TOP), int'(bcpe_pkg::REG_POINT3) + 1)), $urandom());
    cfg_write(bcpe_pkg::REG_POINT0, p0);
    cfg_write(bcpe_pkg::REG_POINT1, p1);
    cfg_write(bcpe_pkg::REG_POINT2, p2);
    cfg_write(bcpe_pkg::REG_POINT3, p3);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_point();
    case ($urandom_range(7))
      0:       return 32'h7FFF_7FFF;
      1:       return 32'h8000_8000;
      2:       return 32'h7FFF_8000;
      3:       return 32'h8000_7FFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [16:0] pick_param();
    case ($urandom_range(7))
      0:       return 17'($urandom_range(int'(PARAM_MAX)));
      1:       return corner_params[$urandom_range(6)];
      default: return 17'($urandom_range(int'(bcpe_pkg::T_ONE)));
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default cubic after reset, parameter corners incl. above one
    foreach (corner_params[k]) send_param(corner_params[k]);

    // straight line one LSB long: t = 1/2 lands exactly halfway
    load_curve(3'd2, 32'h0000_0000, 32'h0001_0001, pick_point(), pick_point());
    send_param(17'd32768);
    send_param(17'd16384);
    send_param(17'd49152);

    load_curve(3'd2, 32'h8000_8000, 32'h7FFF_7FFF, pick_point(), pick_point());
    send_param(17'd0);
    send_param(17'd65536);
    send_param(17'd32768);

    load_curve(3'd3, 32'h7FFF_8000, 32'h8000_7FFF, 32'h7FFF_8000, pick_point());
    send_param(17'd0);
    send_param(17'd32768);
    send_param(17'd65536);
    send_param(17'd21845);

    load_curve(3'd4, 32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_7FFF, 32'h7FFF_8000);
    send_param(17'd0);
    send_param(17'd32768);
    send_param(17'd65536);
    send_param(17'd1);

    for (int k = 0; k < 9; k++) begin
      if (k == 3) begin
        tx_idle_pct  = 67;
        rx_stall_pct = 24;
      end else if (k == 6) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      load_curve(phase_counts[k], pick_point(), pick_point(), pick_point(), pick_point());
      repeat (BATCH_ITEMS) send_param(pick_param());
    end

    drain_points();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bcpe_pkg.sv
rtl/bezier_curve_point_eval.sv
bench/bezier_curve_point_eval_tb.sv
